### hdl/dsrs_pkg.sv
// Shared types and codes for the deadline and seek-distance request scheduler.
package dsrs_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_CANCEL  = 2'd1,
    FUNC_RESCHED = 2'd2,
    FUNC_POP     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_FULL         = 3'd1,
    ST_ISSUED       = 3'd2,
    ST_NONE         = 3'd3,
    ST_CANCELED     = 3'd4,
    ST_CANCEL_DONE  = 3'd5,
    ST_RESCHED_DONE = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DRAIN,
    CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] request_tag;
    logic [15:0] target_id;
    logic [2:0]  command_class;
    logic        has_read_info;
    logic [15:0] file_id;
    logic [47:0] read_offset;
    logic [31:0] read_size;
    logic [47:0] deadline;
    logic [7:0]  priority_req;
    logic [47:0] estimated_completion;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] request_tag_res;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] target;
    logic [2:0]  cls;
    logic        has_read;
    logic [15:0] file;
    logic [47:0] offset;
    logic [31:0] size;
    logic [47:0] deadline;
    logic [7:0]  prio;
    logic [47:0] estimate;
    logic [15:0] order;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic adv;
  } stat_t;

endpackage

### hdl/dsrs_ctrl.sv
// Sequencer that walks the request table once per input item.
module dsrs_ctrl import dsrs_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  stat_t                          stat_i,
  output cmd_t                           cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] idx_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

  ctrl_state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  // Register state and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_SCAN;
          idx_d   = '0;
        end
      end
      CS_SCAN: begin
        if (stat_i.adv) begin
          if (idx_q == LastIdx) begin
            state_d = CS_DRAIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      CS_DRAIN: begin
        if (stat_i.adv) state_d = CS_FINISH;
      end
      CS_FINISH: begin
        if (stat_i.adv) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CS_SCAN:   cmd_o.issue  = stat_i.adv;
      CS_DRAIN:  ;
      CS_FINISH: cmd_o.finish = stat_i.adv;
      default:   ;
    endcase
  end

  assign idx_o = idx_q;

endmodule

### hdl/dsrs_dpath.sv
// Request table, selection compare and result register of the scheduler.
module dsrs_dpath import dsrs_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmd_t                           cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] idx_i,
  input  req_t                           in_data_i,
  output stat_t                          stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output res_t                           out_data_o
);

  localparam int IW = $clog2(TABLE_DEPTH);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;
  req_t   req_q;

  logic [TABLE_DEPTH-1:0] valid_q;
  logic          s_vld_q, s_ent_q;
  logic [IW-1:0] s_idx_q;
  logic          found_q;

  entry_t        best_q;
  logic          best_found_q, best_panic_q, best_same_q;
  logic [47:0]   best_dist_q;
  logic [15:0]   best_age_q;
  logic [IW-1:0] best_idx_q;

  logic [15:0] cnt_q;
  logic [15:0] last_file_q;
  logic        last_fv_q;
  logic [47:0] last_end_q;

  logic out_valid_q;
  res_t out_q;

  logic adv, proc, match, better;
  logic c_panic, c_same;
  logic [47:0] c_dist;
  logic [15:0] c_age;
  logic mem_we;
  entry_t mem_wd;
  logic beat;
  res_t beat_d;
  logic [48:0] end_sum;
  logic [47:0] end_sat;
  logic do_insert, do_resched, do_cancel, take_best;

  assign adv        = !out_valid_q || out_ready_i;
  assign proc       = s_vld_q && adv;
  assign stat_o.adv = adv;

  // Compare terms of the entry under scan
  assign match   = s_ent_q && (rd_q.target == req_q.target_id);
  assign c_panic = rd_q.estimate > rd_q.deadline;
  assign c_same  = last_fv_q && (rd_q.file != 16'd0) && (rd_q.file == last_file_q);
  assign c_dist  = (rd_q.offset >= last_end_q) ? (rd_q.offset - last_end_q)
                                               : (last_end_q - rd_q.offset);
  assign c_age   = cnt_q - rd_q.order;

  // Decide whether the scanned entry beats the current pick
  always_comb begin
    priority if (rd_q.cls != best_q.cls) begin
      better = rd_q.cls > best_q.cls;
    end else if (rd_q.has_read && best_q.has_read && c_panic && best_panic_q &&
                 (rd_q.prio != best_q.prio)) begin
      better = rd_q.prio > best_q.prio;
    end else if (rd_q.has_read && best_q.has_read && c_panic && best_panic_q &&
                 (rd_q.deadline != best_q.deadline)) begin
      better = rd_q.deadline < best_q.deadline;
    end else if (rd_q.has_read && best_q.has_read && (c_panic != best_panic_q)) begin
      better = c_panic;
    end else if (rd_q.has_read && best_q.has_read && !c_panic && !best_panic_q &&
                 c_same && best_same_q && (c_dist != best_dist_q)) begin
      better = c_dist < best_dist_q;
    end else if (rd_q.has_read && best_q.has_read && !c_panic && !best_panic_q &&
                 (c_same != best_same_q)) begin
      better = c_same;
    end else begin
      better = c_age > best_age_q;
    end
  end

  assign do_insert  = proc && (req_q.func == FUNC_INSERT) && !found_q && !s_ent_q;
  assign do_resched = proc && (req_q.func == FUNC_RESCHED) && match && rd_q.has_read;
  assign do_cancel  = proc && (req_q.func == FUNC_CANCEL) && match;
  assign take_best  = proc && (req_q.func == FUNC_POP) && s_ent_q &&
                      (!best_found_q || better);

  // Build the table write word
  always_comb begin
    mem_we = do_insert || do_resched;
    mem_wd = rd_q;
    if (do_insert) begin
      mem_wd.tag      = req_q.request_tag;
      mem_wd.target   = req_q.target_id;
      mem_wd.cls      = req_q.command_class;
      mem_wd.has_read = req_q.has_read_info;
      mem_wd.file     = req_q.file_id;
      mem_wd.offset   = req_q.read_offset;
      mem_wd.size     = req_q.read_size;
      mem_wd.deadline = req_q.deadline;
      mem_wd.prio     = req_q.priority_req;
      mem_wd.estimate = req_q.estimated_completion;
      mem_wd.order    = cnt_q;
    end else begin
      mem_wd.deadline = req_q.deadline;
      mem_wd.prio     = req_q.priority_req;
    end
  end

  // Table memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[s_idx_q] <= mem_wd;
    if (cmd_i.issue) rd_q <= mem_q[idx_i];
  end

  // End offset of the issued read, saturated
  assign end_sum = {1'b0, best_q.offset} + {17'd0, best_q.size};
  assign end_sat = end_sum[48] ? {48{1'b1}} : end_sum[47:0];

  // Pick the next result beat
  always_comb begin
    beat   = 1'b0;
    beat_d = out_q;
    if (do_cancel) begin
      beat   = 1'b1;
      beat_d = '{status: ST_CANCELED, request_tag_res: rd_q.tag, last: 1'b0};
    end else if (cmd_i.finish) begin
      beat = 1'b1;
      unique case (req_q.func)
        FUNC_INSERT: beat_d = '{status: found_q ? ST_INSERTED : ST_FULL,
                                request_tag_res: req_q.request_tag, last: 1'b1};
        FUNC_CANCEL: beat_d = '{status: ST_CANCEL_DONE,
                                request_tag_res: req_q.request_tag, last: 1'b1};
        FUNC_RESCHED: beat_d = '{status: ST_RESCHED_DONE,
                                 request_tag_res: req_q.request_tag, last: 1'b1};
        FUNC_POP: beat_d = best_found_q ?
                           '{status: ST_ISSUED, request_tag_res: best_q.tag, last: 1'b1} :
                           '{status: ST_NONE, request_tag_res: 16'd0, last: 1'b1};
        default: beat_d = out_q;
      endcase
    end
  end

  // Payload registers: item, scan stage, best pick
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    if (cmd_i.issue) s_idx_q <= idx_i;
    if (take_best) begin
      best_q       <= rd_q;
      best_panic_q <= c_panic;
      best_same_q  <= c_same;
      best_dist_q  <= c_dist;
      best_age_q   <= c_age;
      best_idx_q   <= s_idx_q;
    end
    if (beat) out_q <= beat_d;
  end

  // Control state: valid bits, scan stage, counters, last issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      s_vld_q      <= 1'b0;
      s_ent_q      <= 1'b0;
      found_q      <= 1'b0;
      best_found_q <= 1'b0;
      cnt_q        <= '0;
      last_file_q  <= '0;
      last_fv_q    <= 1'b0;
      last_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv) s_vld_q <= cmd_i.issue;
      if (cmd_i.issue) s_ent_q <= valid_q[idx_i];
      if (cmd_i.load) begin
        found_q      <= 1'b0;
        best_found_q <= 1'b0;
      end
      if (do_insert) begin
        found_q          <= 1'b1;
        valid_q[s_idx_q] <= 1'b1;
      end
      if (do_cancel) valid_q[s_idx_q] <= 1'b0;
      if (take_best) best_found_q <= 1'b1;
      if (cmd_i.finish && (req_q.func == FUNC_INSERT) && found_q) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.finish && (req_q.func == FUNC_POP) && best_found_q) begin
        valid_q[best_idx_q] <= 1'b0;
        if (best_q.file != 16'd0) begin
          last_file_q <= best_q.file;
          last_fv_q   <= 1'b1;
          last_end_q  <= end_sat;
        end
      end
      if (beat) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/deadline_seek_request_scheduler.sv
// Top level: deadline and seek-distance I/O request scheduler.
// Every item scans all TABLE_DEPTH table slots, one per cycle through the
// single read port of the table memory while out_ready_i does not stall the
// result beat. The scan is followed by a drain and a finish step; an item is
// accepted only in idle, so a new item waits until the last one has finished.
// Cancel sends one beat per removed entry during the scan, then a closing beat.
// Reset (rst_ni low, asynchronous) empties the table and clears counters and last issue.
module deadline_seek_request_scheduler import dsrs_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;
  logic [$clog2(TABLE_DEPTH)-1:0] idx;

  dsrs_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  dsrs_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .in_data_i   (in_data_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/dsrs_checker.sv
// Port-level checks for the request scheduler, bound to the top level.
module dsrs_checker import dsrs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input res_t out_data_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Stay busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // Only removed-entry beats are not final
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.status != ST_CANCELED)))
    else $error("last flag does not match status");

  // Empty pop reports tag zero
  a_none_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_NONE) |-> out_data_o.request_tag_res == 16'd0)
    else $error("empty pop with nonzero tag");

endmodule

bind deadline_seek_request_scheduler dsrs_checker u_chk (.*);
